// ----- hw/rtl/tsac_pkg.sv -----
`timescale 1ns / 1ps

package tsac_pkg;

    // Fixed field widths
    localparam int ANGLE_BITS = 8;
    localparam int PULSE_BITS = 12;
    localparam int GAIN_BITS  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DB_BITS    = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Angle and pulse constants
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX  = 8'd180;
    localparam logic [ANGLE_BITS-1:0] STOP_ANGLE = 8'd90;
    localparam logic [PULSE_BITS-1:0] PULSE_BASE = 12'd500;
    // 2000/180 scaled by 2^16; exact floor for angles 0..180
    localparam logic [27:0] PULSE_RECIP = 28'd728200;
    localparam int PULSE_SHIFT = 16;

    // Frame width held after reset
    localparam int WIDTH_RESET = 640;
    localparam int WIDTH_RESET_BITS = $clog2(WIDTH_RESET + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_STEP = 3'd4;

    // Configuration reset values
    localparam logic                  RST_INVERT   = 1'b0;
    localparam logic [DB_BITS-1:0]    RST_DEADBAND = 12'd20;
    localparam logic [ANGLE_BITS-1:0] RST_CENTER   = 8'd90;
    localparam logic [GAIN_BITS-1:0]  RST_GAIN     = 16'd26;
    localparam logic [ANGLE_BITS-1:0] RST_MAX_STEP = 8'd5;

    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [PULSE_BITS-1:0] t_pulse;

    typedef struct packed {
        logic                      invert;
        logic [DB_BITS-1:0]        deadband;
        t_angle                    center;
        logic signed [GAIN_BITS-1:0] gain;
        t_angle                    max_step;
    } t_cfg;

endpackage

// ----- hw/rtl/tsac_mul.sv -----
`timescale 1ns / 1ps

// Bit-serial unsigned multiplier: one multiplier bit per cycle, product shifts right
module tsac_mul #(
    parameter int MAG_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [MAG_BITS-1:0]                     i_mag,
    input  logic [tsac_pkg::GAIN_BITS-1:0]          i_gain_mag,
    output logic                                    o_done,
    output logic [MAG_BITS+tsac_pkg::GAIN_BITS-1:0] o_prod
);

    localparam int GB = tsac_pkg::GAIN_BITS;
    localparam int CNT_BITS = $clog2(GB);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [GB-1:0]          r_gain_sr;
    logic [MAG_BITS-1:0]    r_mag;
    logic [MAG_BITS+GB-1:0] r_prod;

    logic [MAG_BITS-1:0]    w_addend;
    logic [MAG_BITS:0]      w_sum;

    // Partial sum on the upper part only
    assign w_addend = r_gain_sr[0] ? r_mag : '0;
    assign w_sum    = {1'b0, r_prod[MAG_BITS+GB-1:GB]} + {1'b0, w_addend};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(GB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod    <= '0;
            r_gain_sr <= i_gain_mag;
            r_mag     <= i_mag;
        end else if (r_busy) begin
            r_prod    <= {w_sum, r_prod[GB-1:1]};
            r_gain_sr <= {1'b0, r_gain_sr[GB-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/tsac_pulse.sv -----
`timescale 1ns / 1ps

// Angle to servo pulse width: 500 + angle*2000/180 via reciprocal multiply
module tsac_pulse (
    input  tsac_pkg::t_angle i_angle,
    output tsac_pkg::t_pulse o_pulse
);

    logic [27:0] w_prod;

    assign w_prod  = {20'd0, i_angle} * tsac_pkg::PULSE_RECIP;
    assign o_pulse = tsac_pkg::PULSE_BASE
                   + tsac_pkg::PULSE_BITS'(w_prod[27:tsac_pkg::PULSE_SHIFT]);

endmodule

// ----- hw/rtl/tracking_servo_angle_controller_core.sv -----
`timescale 1ns / 1ps
// A normal word passes the check, bit-serial gain multiply, target, step and pulse states;
// a word inside the deadband goes from check to pulse, and a stop request goes straight to pulse.
// No new word is taken until the last one has left the pulse state, which waits for a free output register.
// A new word is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) restores the state, config and output-valid registers, angle 90 and frame width 640.
module tracking_servo_angle_controller_core #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Item input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [PIXEL_BITS-1:0]                  i_object_x,
    input  logic [PIXEL_BITS-1:0]                  i_new_frame_width,
    input  logic                                   i_stop_request,
    // Result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [tsac_pkg::ANGLE_BITS-1:0]        o_commanded_angle,
    output logic [tsac_pkg::PULSE_BITS-1:0]        o_pulse_width_us,
    output logic                                   o_new_command,
    // Configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tsac_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [tsac_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int WS  = (PIXEL_BITS > tsac_pkg::WIDTH_RESET_BITS) ?
                         PIXEL_BITS : tsac_pkg::WIDTH_RESET_BITS;
    localparam int EW  = WS + 1;
    localparam int CW  = (WS > tsac_pkg::DB_BITS) ? WS : tsac_pkg::DB_BITS;
    localparam int GB  = tsac_pkg::GAIN_BITS;
    localparam int FB  = tsac_pkg::FRAC_BITS;
    localparam int QW  = WS + GB - FB;
    localparam int TW  = QW + 1;
    localparam int AB  = tsac_pkg::ANGLE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_TGT   = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_PULSE = 3'd5;

    logic [2:0]              r_state;
    tsac_pkg::t_cfg          r_cfg;
    tsac_pkg::t_angle        r_cur;
    logic [WS-1:0]           r_width;
    logic signed [EW-1:0]    r_err;
    logic                    r_neg;
    tsac_pkg::t_angle        r_target;
    logic                    r_issued;
    logic                    r_out_valid;
    tsac_pkg::t_angle        r_out_angle;
    tsac_pkg::t_pulse        r_out_pulse;
    logic                    r_out_new;

    logic                    w_accept;
    logic                    w_out_free;
    logic [WS-1:0]           w_width_eff;
    logic signed [EW-1:0]    w_err_raw;
    logic signed [EW-1:0]    w_err;
    logic [WS-1:0]           w_mag;
    logic                    w_outside;
    logic [GB-1:0]           w_gain_mag;
    logic                    w_mul_start;
    logic                    w_mul_done;
    logic [WS+GB-1:0]        w_prod;
    logic [QW-1:0]           w_q;
    logic [TW-1:0]           w_center_ext;
    logic [TW-1:0]           w_sum_pos;
    logic [TW-1:0]           w_sum_neg;
    logic [TW-1:0]           w_tgt_wide;
    tsac_pkg::t_angle        n_target;
    logic                    w_up;
    tsac_pkg::t_angle        w_dist;
    tsac_pkg::t_angle        n_cur;
    tsac_pkg::t_pulse        w_pulse;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Pixel error against half of the effective frame width
    assign w_width_eff = (i_new_frame_width != '0) ? WS'(i_new_frame_width) : r_width;
    assign w_err_raw   = $signed({{(EW-PIXEL_BITS){1'b0}}, i_object_x})
                       - $signed({2'b00, w_width_eff[WS-1:1]});

    // Direction, magnitude and deadband check
    assign w_err      = r_cfg.invert ? -r_err : r_err;
    assign w_mag      = w_err[EW-1] ? WS'(-w_err) : WS'(w_err);
    assign w_outside  = CW'(w_mag) > CW'(r_cfg.deadband);
    assign w_gain_mag = r_cfg.gain[GB-1] ? GB'(-r_cfg.gain) : GB'(r_cfg.gain);
    assign w_mul_start = (r_state == S_CHK) && w_outside;

    tsac_mul #(
        .MAG_BITS (WS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mul_start),
        .i_mag      (w_mag),
        .i_gain_mag (w_gain_mag),
        .o_done     (w_mul_done),
        .o_prod     (w_prod)
    );

    // Target: center plus scaled error (truncated toward zero), clamped to 0..180
    assign w_q          = w_prod[WS+GB-1:FB];
    assign w_center_ext = TW'(r_cfg.center);
    assign w_sum_pos    = w_center_ext + {1'b0, w_q};
    assign w_sum_neg    = w_center_ext - {1'b0, w_q};
    always_comb begin
        if (r_neg && ({1'b0, w_q} > w_center_ext)) begin
            w_tgt_wide = '0;
        end else if (r_neg) begin
            w_tgt_wide = w_sum_neg;
        end else begin
            w_tgt_wide = w_sum_pos;
        end
        if (w_tgt_wide > TW'(tsac_pkg::ANGLE_MAX)) begin
            n_target = tsac_pkg::ANGLE_MAX;
        end else begin
            n_target = w_tgt_wide[AB-1:0];
        end
    end

    // Slew limit toward the target
    assign w_up   = r_target > r_cur;
    assign w_dist = w_up ? (r_target - r_cur) : (r_cur - r_target);
    always_comb begin
        if (w_dist > r_cfg.max_step) begin
            n_cur = w_up ? (r_cur + r_cfg.max_step) : (r_cur - r_cfg.max_step);
        end else begin
            n_cur = r_target;
        end
    end

    tsac_pulse u_pulse (
        .i_angle (r_cur),
        .o_pulse (w_pulse)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert   <= tsac_pkg::RST_INVERT;
            r_cfg.deadband <= tsac_pkg::RST_DEADBAND;
            r_cfg.center   <= tsac_pkg::RST_CENTER;
            r_cfg.gain     <= tsac_pkg::RST_GAIN;
            r_cfg.max_step <= tsac_pkg::RST_MAX_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tsac_pkg::CFG_INVERT:   r_cfg.invert   <= i_cfg_data[0];
                tsac_pkg::CFG_DEADBAND: r_cfg.deadband <= i_cfg_data[tsac_pkg::DB_BITS-1:0];
                tsac_pkg::CFG_CENTER:   r_cfg.center   <= i_cfg_data[AB-1:0];
                tsac_pkg::CFG_GAIN:     r_cfg.gain     <= $signed(i_cfg_data[GB-1:0]);
                tsac_pkg::CFG_MAX_STEP: r_cfg.max_step <= i_cfg_data[AB-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= tsac_pkg::STOP_ANGLE;
            r_width     <= WS'(tsac_pkg::WIDTH_RESET);
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register: load a finished word, else drain on a free edge
            if (r_state == S_PULSE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_new_frame_width != '0) begin
                            r_width <= WS'(i_new_frame_width);
                        end
                        if (i_stop_request) begin
                            r_cur    <= tsac_pkg::STOP_ANGLE;
                            r_issued <= 1'b1;
                            r_state  <= S_PULSE;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (w_outside) begin
                        r_state <= S_MUL;
                    end else begin
                        r_issued <= 1'b0;
                        r_state  <= S_PULSE;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_TGT;
                    end
                end
                S_TGT: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_cur    <= n_cur;
                    r_issued <= 1'b1;
                    r_state  <= S_PULSE;
                end
                S_PULSE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= w_err_raw;
        end
        if (r_state == S_CHK) begin
            r_neg <= w_err[EW-1] ^ r_cfg.gain[GB-1];
        end
        if (r_state == S_TGT) begin
            r_target <= n_target;
        end
        if (r_state == S_PULSE && w_out_free) begin
            r_out_angle <= r_cur;
            r_out_pulse <= w_pulse;
            r_out_new   <= r_issued;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_commanded_angle = r_out_angle;
    assign o_pulse_width_us  = r_out_pulse;
    assign o_new_command     = r_out_new;
    assign o_cfg_ready       = 1'b1;

endmodule

// ----- hw/rtl/tsac_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the controller
module tsac_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [tsac_pkg::ANGLE_BITS-1:0]    o_commanded_angle,
    input logic [tsac_pkg::PULSE_BITS-1:0]    o_pulse_width_us,
    input logic                               o_new_command
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted while previous one in flight");

    // Result angle stays in servo range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_commanded_angle <= tsac_pkg::ANGLE_MAX))
        else $error("commanded angle out of range");

    // Pulse width stays within 500..2500 us
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pulse_width_us >= 12'd500 && o_pulse_width_us <= 12'd2500))
        else $error("pulse width out of range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_commanded_angle) && $stable(o_pulse_width_us)
         && $stable(o_new_command)))
        else $error("stalled result changed");

endmodule

bind tracking_servo_angle_controller_core tsac_checker u_tsac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_commanded_angle (o_commanded_angle),
    .o_pulse_width_us  (o_pulse_width_us),
    .o_new_command     (o_new_command)
);

// ----- verif/tracking_servo_angle_controller_core_chk.sv -----
`timescale 1ns / 1ps

module tracking_servo_angle_controller_core_chk #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [PIXEL_BITS-1:0]                  i_object_x,
    input  logic [PIXEL_BITS-1:0]                  i_new_frame_width,
    input  logic                                   i_stop_request,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic [tsac_pkg::ANGLE_BITS-1:0]        i_commanded_angle,
    input  logic [tsac_pkg::PULSE_BITS-1:0]        i_pulse_width_us,
    input  logic                                   i_new_command,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [tsac_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [tsac_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    localparam int     PULSE_SPAN = 2000;
    localparam longint GAIN_ONE   = longint'(1) << tsac_pkg::FRAC_BITS;

    typedef struct packed {
        tsac_pkg::t_angle angle;
        tsac_pkg::t_pulse pulse;
        logic             issued;
    } t_servo_cmd;

    // Shadow copy of the control registers
    logic                                  invert_q;
    logic [tsac_pkg::DB_BITS-1:0]          deadband_q;
    tsac_pkg::t_angle                      center_q;
    logic signed [tsac_pkg::GAIN_BITS-1:0] gain_q;
    tsac_pkg::t_angle                      step_q;

    // Shadow copy of the servo state
    tsac_pkg::t_angle                      angle_q;
    logic [PIXEL_BITS-1:0]                 width_q;

    t_servo_cmd cmd_q[$];
    int         fail_cnt = 0;
    int         cmds_in_flight = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = cmds_in_flight;

    function automatic tsac_pkg::t_pulse pulse_of(tsac_pkg::t_angle a);
        return tsac_pkg::t_pulse'(int'(tsac_pkg::PULSE_BASE)
                                  + (int'(a) * PULSE_SPAN) / int'(tsac_pkg::ANGLE_MAX));
    endfunction

    // Proportional step with deadband, clamp and slew limit; updates the shadow state
    function t_servo_cmd track_step(logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] w,
                                    logic stop);
        longint     err;
        longint     mag;
        longint     tgt;
        longint     delta;
        longint     lim;
        t_servo_cmd cmd;
        cmd.issued = 1'b0;
        if (w != '0) width_q = w;
        if (stop) begin
            angle_q    = tsac_pkg::STOP_ANGLE;
            cmd.issued = 1'b1;
        end else begin
            err = longint'(x) - longint'(width_q >> 1);
            if (invert_q) err = -err;
            mag = (err < 0) ? -err : err;
            if (mag > longint'(deadband_q)) begin
                // SV division truncates toward zero, as the gain product requires
                tgt = longint'(center_q) + (err * longint'(gain_q)) / GAIN_ONE;
                if (tgt < 0) tgt = 0;
                if (tgt > longint'(tsac_pkg::ANGLE_MAX)) tgt = longint'(tsac_pkg::ANGLE_MAX);
                lim   = longint'(step_q);
                delta = tgt - longint'(angle_q);
                if (delta > lim) delta = lim;
                if (delta < -lim) delta = -lim;
                angle_q    = tsac_pkg::t_angle'(longint'(angle_q) + delta);
                cmd.issued = 1'b1;
            end
        end
        cmd.angle = angle_q;
        cmd.pulse = pulse_of(angle_q);
        return cmd;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        fail_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Watch the three channels at each edge
    always @(posedge i_clk) begin
        t_servo_cmd want;
        if (!i_rst_n) begin
            invert_q   = tsac_pkg::RST_INVERT;
            deadband_q = tsac_pkg::RST_DEADBAND;
            center_q   = tsac_pkg::RST_CENTER;
            gain_q     = tsac_pkg::RST_GAIN;
            step_q     = tsac_pkg::RST_MAX_STEP;
            angle_q    = tsac_pkg::STOP_ANGLE;
            width_q    = PIXEL_BITS'(tsac_pkg::WIDTH_RESET);
            cmd_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tsac_pkg::CFG_INVERT:
                        invert_q   = i_cfg_data[0];
                    tsac_pkg::CFG_DEADBAND:
                        deadband_q = i_cfg_data[tsac_pkg::DB_BITS-1:0];
                    tsac_pkg::CFG_CENTER:
                        center_q   = i_cfg_data[tsac_pkg::ANGLE_BITS-1:0];
                    tsac_pkg::CFG_GAIN:
                        gain_q     = i_cfg_data[tsac_pkg::GAIN_BITS-1:0];
                    tsac_pkg::CFG_MAX_STEP:
                        step_q     = i_cfg_data[tsac_pkg::ANGLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                cmd_q.push_back(track_step(i_object_x, i_new_frame_width, i_stop_request));
            if (i_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected word, expected none, %s %0d pulse %0d cmd %0d",
                             $time, "actual angle", i_commanded_angle, i_pulse_width_us,
                             i_new_command);
                end else begin
                    want = cmd_q.pop_front();
                    if (i_commanded_angle !== want.angle)
                        note_mismatch("commanded_angle", 32'(want.angle),
                                      32'(i_commanded_angle));
                    if (i_pulse_width_us !== want.pulse)
                        note_mismatch("pulse_width_us", 32'(want.pulse),
                                      32'(i_pulse_width_us));
                    if (i_new_command !== want.issued)
                        note_mismatch("new_command", 32'(want.issued), 32'(i_new_command));
                end
            end
        end
        cmds_in_flight <= cmd_q.size();
    end

endmodule

// ----- verif/tracking_servo_angle_controller_core_tb.sv -----
`timescale 1ns / 1ps

module tracking_servo_angle_controller_core_tb;

    localparam int PIXEL_BITS      = 12;
    localparam int PIXEL_MAX       = (1 << PIXEL_BITS) - 1;
    localparam int RUN_LIMIT       = 1_000_000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int GAIN_MIN        = -32768;
    localparam int GAIN_MAX        = 32767;
    localparam int STEP_MAX        = 255;
    localparam int HOLD1_AT        = 200;
    localparam int HOLD2_AT        = 900;
    localparam int ANGLE_TOP       = int'(tsac_pkg::ANGLE_MAX);
    // Index past the last register; writes to it must be ignored
    localparam logic [tsac_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    wire                                 in_stall;
    logic [PIXEL_BITS-1:0]               object_x = '0;
    logic [PIXEL_BITS-1:0]               frame_w = '0;
    logic                                stop_req = 1'b0;
    wire                                 out_valid;
    logic                                out_stall = 1'b0;
    wire [tsac_pkg::ANGLE_BITS-1:0]      angle;
    wire [tsac_pkg::PULSE_BITS-1:0]      pulse;
    wire                                 new_cmd;
    logic                                cfg_valid = 1'b0;
    wire                                 cfg_ready;
    logic [tsac_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [tsac_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int sent_count = 0;
    int cycle_cnt = 0;
    int cur_width = tsac_pkg::WIDTH_RESET;
    int cur_db = int'(tsac_pkg::RST_DEADBAND);
    bit calm = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tracking_servo_angle_controller_core #(
        .PIXEL_BITS(PIXEL_BITS)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_object_x        (object_x),
        .i_new_frame_width (frame_w),
        .i_stop_request    (stop_req),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_commanded_angle (angle),
        .o_pulse_width_us  (pulse),
        .o_new_command     (new_cmd),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    tracking_servo_angle_controller_core_chk #(
        .PIXEL_BITS(PIXEL_BITS)
    ) i_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_object_x        (object_x),
        .i_new_frame_width (frame_w),
        .i_stop_request    (stop_req),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_commanded_angle (angle),
        .i_pulse_width_us  (pulse),
        .i_new_command     (new_cmd),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic int DB_MAX();
        return (1 << tsac_pkg::DB_BITS) - 1;
    endfunction

    task automatic send_word(input int x, input int w, input bit s);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        object_x <= x[PIXEL_BITS-1:0];
        frame_w  <= w[PIXEL_BITS-1:0];
        stop_req <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
        if (w != 0) cur_width = w;
    endtask

    // Drop valid and wait until every result is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tsac_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [tsac_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write all registers back to back; unused upper data bits carry junk
    task automatic program_regs(input bit inv, input int db, input int ctr, input int gain,
                                input int step, input bit spare);
        write_reg(tsac_pkg::CFG_INVERT,   {15'($urandom), inv});
        write_reg(tsac_pkg::CFG_DEADBAND, {4'($urandom), 12'(db)});
        write_reg(tsac_pkg::CFG_CENTER,   {8'($urandom), 8'(ctr)});
        write_reg(tsac_pkg::CFG_GAIN,     16'(gain));
        write_reg(tsac_pkg::CFG_MAX_STEP, {8'($urandom), 8'(step)});
        if (spare) write_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        cur_db = db;
    endtask

    task automatic random_config();
        int r;
        int db;
        int ctr;
        int gain;
        int step;
        r = $urandom_range(0, 99);
        db = (r < 10) ? 0 : (r < 15) ? DB_MAX() :
             (r < 75) ? int'($urandom_range(0, 40)) : int'($urandom_range(0, 600));
        r = $urandom_range(0, 99);
        ctr = (r < 10) ? 0 : (r < 20) ? ANGLE_TOP :
              (r < 25) ? int'($urandom_range(181, 255)) : int'($urandom_range(0, 180));
        r = $urandom_range(0, 99);
        if (r < 8) gain = GAIN_MIN;
        else if (r < 16) gain = GAIN_MAX;
        else if (r < 20) gain = 0;
        else if (r < 80) gain = int'($urandom_range(0, 1200)) - 600;
        else gain = int'($urandom_range(0, 65535)) + GAIN_MIN;
        r = $urandom_range(0, 99);
        step = (r < 10) ? 0 : (r < 20) ? ANGLE_TOP :
               (r < 25) ? int'($urandom_range(181, STEP_MAX)) : int'($urandom_range(1, 20));
        program_regs($urandom_range(0, 1), db, ctr, gain, step, $urandom_range(0, 3) == 0);
    endtask

    // Columns cluster around the deadband edges, with some spread and some noise
    task automatic random_item();
        int r;
        int w;
        int x;
        int half;
        bit s;
        s = ($urandom_range(0, 99) < 6);
        r = $urandom_range(0, 99);
        w = 0;
        if (r < 8) w = $urandom_range(1, PIXEL_MAX);
        else if (r == 8) w = PIXEL_MAX;
        else if (r == 9) w = $urandom_range(1, 8);
        half = ((w != 0) ? w : cur_width) / 2;
        r = $urandom_range(0, 99);
        if (r < 50) x = half - cur_db - 4 + int'($urandom_range(0, 2 * cur_db + 8));
        else if (r < 80) x = half - 400 + int'($urandom_range(0, 800));
        else x = $urandom_range(0, PIXEL_MAX);
        if (x < 0) x = 0;
        if (x > PIXEL_MAX) x = PIXEL_MAX;
        send_word(x, w, s);
    endtask

    // Result side: random stalls, quiet stretches, and two long hold-offs
    initial begin
        int holds_done;
        int r;
        holds_done = 0;
        forever begin
            r = $urandom_range(0, 99);
            if (holds_done < 2 && sent_count >= ((holds_done == 0) ? HOLD1_AT : HOLD2_AT)) begin
                out_stall <= 1'b1;
                repeat ((holds_done == 0) ? 400 : 200) @(posedge clk);
                holds_done++;
            end else if (r < 15) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(40, 200)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b1;
                r = $urandom_range(0, 99);
                repeat ((r < 70) ? $urandom_range(1, 3) :
                        (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: width extremes, deadband edges, stops
        send_word(0, 0, 1'b0);
        send_word(PIXEL_MAX, 0, 1'b0);
        send_word(320, 0, 1'b0);           // zero error
        send_word(340, 0, 1'b0);           // error equals deadband
        send_word(341, 0, 1'b0);           // one past deadband
        send_word(299, 0, 1'b0);
        send_word(0, PIXEL_MAX, 1'b0);     // widest frame
        send_word(2047, 0, 1'b0);
        send_word(100, 100, 1'b1);         // stop still stores new width
        send_word(50, 0, 1'b0);
        send_word(PIXEL_MAX, 0, 1'b0);
        send_word(0, 0, 1'b1);
        settle();

        // Inverted, no deadband, most negative gain, no slew limit
        program_regs(1'b1, 0, ANGLE_TOP, GAIN_MIN, ANGLE_TOP, 1'b1);
        send_word(0, 640, 1'b0);
        send_word(321, 0, 1'b0);
        send_word(319, 0, 1'b0);
        send_word(PIXEL_MAX, 0, 1'b0);
        send_word(320, 0, 1'b0);
        send_word(0, 0, 1'b1);
        settle();

        // Zero step: angle frozen but still commanded
        program_regs(1'b0, 0, 0, GAIN_MAX, 0, 1'b0);
        send_word(0, 0, 1'b0);
        send_word(PIXEL_MAX, PIXEL_MAX, 1'b0);
        send_word(2047, 0, 1'b0);
        settle();

        // Center and step beyond 180, negative product truncated toward zero
        program_regs(1'b1, 2, STEP_MAX, -1, STEP_MAX, 1'b0);
        send_word(10, 640, 1'b0);
        send_word(330, 0, 1'b0);
        send_word(1, 1, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            random_config();
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 50 == 0) calm = ($urandom_range(0, 2) == 0);
                random_item();
            end
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
